@@ sv/utt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types, constants and a helper function of the triangle tessellator.
// ----------------------------------------------------------------------------
package utt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ID_WIDTH_DEF    = 24;
    localparam int MAX_SUB_DEF     = 6;

    // Segment count, row and column indexes all fit in this width.
    localparam int SUB_W     = 3;
    localparam int NUM_VERT  = 3;
    localparam int NUM_COORD = 3;
    localparam int VSEL_W    = 2;
    // Holds i*r0 + j*r1 + k*r2, which never exceeds n*(n-1).
    localparam int RS_W      = 5;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIV    = 5'b00010,
        ST_SETUP  = 5'b00100,
        ST_POINTS = 5'b01000,
        ST_TRIS   = 5'b10000
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUB_W-1:0] divisor;
    } div_ctrl_t;

    // floor((2*rs + n) / (2*n)) for the small remainder sum: rounds rs/n to
    // nearest with ties going up.
    function automatic logic [SUB_W-1:0] round_frac(input logic [RS_W-1:0] rs,
                                                    input logic [SUB_W-1:0] n);
        logic [RS_W+1:0] num;
        logic [RS_W+1:0] lim;
        logic [SUB_W-1:0] q;
        num = {1'b0, rs, 1'b0} + (RS_W+2)'(n);
        q   = '0;
        for (int m = 1; m <= MAX_SUB_DEF; m++)
        begin
            lim = (RS_W+2)'(2 * m) * (RS_W+2)'(n);
            if (num >= lim)
            begin
                q = SUB_W'(m);
            end
        end
        return q;
    endfunction

endpackage
`default_nettype wire

@@ sv/utt_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_div
// Bit-serial floor divider of three signed coordinates by a small divisor.
// ----------------------------------------------------------------------------
module utt_div #(
    parameter int COORD_WIDTH = utt_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire utt_pkg::div_ctrl_t     ctrl,
    input  wire logic [COORD_WIDTH-1:0] dividend [utt_pkg::NUM_COORD],
    output logic                        done,
    output logic [COORD_WIDTH-1:0]      quotient [utt_pkg::NUM_COORD],
    output logic [utt_pkg::SUB_W-1:0]   remainder [utt_pkg::NUM_COORD]
);
    import utt_pkg::*;

    localparam int CNT_W = $clog2(COORD_WIDTH);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SUB_W-1:0]       n_reg;
    logic [COORD_WIDTH-2:0] sh_reg  [NUM_COORD];
    logic [COORD_WIDTH-1:0] quo_reg [NUM_COORD];
    logic [SUB_W-1:0]       rem_reg [NUM_COORD];
    logic [SUB_W-1:0]       rem_next [NUM_COORD];
    logic                   qbit    [NUM_COORD];
    logic [SUB_W:0]         trial   [NUM_COORD];

    // One restoring step per lane: the partial remainder stays below n, so a
    // single compare and subtract settles each quotient bit.
    always_comb
    begin
        for (int c = 0; c < NUM_COORD; c++)
        begin
            trial[c] = {rem_reg[c], sh_reg[c][COORD_WIDTH-2]};
            qbit[c]  = (trial[c] >= {1'b0, n_reg});
            if (qbit[c])
            begin
                rem_next[c] = SUB_W'(trial[c] - {1'b0, n_reg});
            end
            else
            begin
                rem_next[c] = trial[c][SUB_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(COORD_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            done_reg <= !ctrl.start && busy_reg && (cnt_reg == CNT_W'(1));
        end
    end

    // A negative value starts from quotient -1 and remainder n-1, which keeps
    // the remainder non-negative and makes the result a floor division.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            n_reg <= ctrl.divisor;
            for (int c = 0; c < NUM_COORD; c++)
            begin
                sh_reg[c]  <= dividend[c][COORD_WIDTH-2:0];
                quo_reg[c] <= {COORD_WIDTH{dividend[c][COORD_WIDTH-1]}};
                rem_reg[c] <= dividend[c][COORD_WIDTH-1] ?
                              SUB_W'(ctrl.divisor - SUB_W'(1)) : '0;
            end
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < NUM_COORD; c++)
            begin
                sh_reg[c]  <= {sh_reg[c][COORD_WIDTH-3:0], 1'b0};
                quo_reg[c] <= {quo_reg[c][COORD_WIDTH-2:0], qbit[c]};
                rem_reg[c] <= rem_next[c];
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ sv/uniform_triangle_tessellator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_triangle_tessellator_core
// Splits each triangle into n*n sub-triangles: emits the grid points first,
// then the sub-triangles as point ids.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Contents
//  cfg       in         cfg_we                    subdivisions
//  s_axis    in         s_axis_tvalid/tready      three vertices, x y z each
//  m_axis    out        m_axis_tvalid/tready      one point or one sub-triangle
//
// Before its first result, an item passes through the bit-serial divider, which
// is reused for each of the three vertices in turn; the item then gives one result
// per cycle while the output does not stall: (n+1)(n+2)/2 points and n*n triangles.
// Output stalls hold the sequencer; a new item is taken once the previous
// item's last result sits in the output register.
// Reset clears the id counter, the overflow flag and sets subdivisions to 1.
// ----------------------------------------------------------------------------
module uniform_triangle_tessellator_core #(
    parameter int  COORD_WIDTH      = utt_pkg::COORD_WIDTH_DEF,
    parameter int  ID_WIDTH         = utt_pkg::ID_WIDTH_DEF,
    parameter int  MAX_SUBDIVISIONS = utt_pkg::MAX_SUB_DEF,
    localparam int IN_BITS          = utt_pkg::NUM_VERT * utt_pkg::NUM_COORD * COORD_WIDTH,
    localparam int IN_TDATA_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS         = 3 * COORD_WIDTH + 4 * ID_WIDTH + 1,
    localparam int OUT_TDATA_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [utt_pkg::SUB_W-1:0] cfg_wdata,     // subdivisions
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz
    input  wire logic [IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // px, py, pz, point_id, vertex_a, vertex_b, vertex_c, id_overflow
    output logic [OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                           m_axis_tuser,  // kind
    output logic                           m_axis_tlast   // last
);
    import utt_pkg::*;

    localparam int MAX_POINTS = (MAX_SUBDIVISIONS + 1) * (MAX_SUBDIVISIONS + 2) / 2;
    localparam int PIDX_W     = $clog2(MAX_POINTS);
    localparam logic [ID_WIDTH-1:0] ID_MAX = {ID_WIDTH{1'b1}};

    state_t                 state_reg;
    state_t                 state_next;
    logic [SUB_W-1:0]       sub_reg;
    logic [SUB_W-1:0]       n_reg;
    logic [SUB_W-1:0]       n_clamped;
    logic                   div_start_reg;
    logic [VSEL_W-1:0]      vsel_reg;
    logic                   in_accept;

    logic [COORD_WIDTH-1:0] vin_reg [NUM_VERT][NUM_COORD];
    logic [COORD_WIDTH-1:0] qv_reg  [NUM_VERT][NUM_COORD];
    logic [SUB_W-1:0]       rv_reg  [NUM_VERT][NUM_COORD];

    div_ctrl_t              div_ctrl;
    logic                   div_done;
    logic [COORD_WIDTH-1:0] div_q [NUM_COORD];
    logic [SUB_W-1:0]       div_r [NUM_COORD];

    logic [COORD_WIDTH-1:0] cur_v_reg  [NUM_COORD];
    logic [COORD_WIDTH-1:0] row_v_reg  [NUM_COORD];
    logic [COORD_WIDTH-1:0] d1_reg     [NUM_COORD];
    logic [COORD_WIDTH-1:0] d0_reg     [NUM_COORD];
    logic [RS_W-1:0]        cur_rs_reg [NUM_COORD];
    logic [RS_W-1:0]        row_rs_reg [NUM_COORD];
    logic [RS_W-1:0]        dr1_reg    [NUM_COORD];
    logic [RS_W-1:0]        dr0_reg    [NUM_COORD];
    logic [COORD_WIDTH-1:0] pt_val     [NUM_COORD];

    logic [SUB_W-1:0]       i_reg;
    logic [SUB_W-1:0]       j_reg;
    logic                   pt_row_end;
    logic [PIDX_W-1:0]      tri_s_reg;
    logic [PIDX_W-1:0]      tri_t_reg;
    logic                   tri_hi_reg;
    logic [SUB_W:0]         tri_sum;
    logic                   tri_has_hi;
    logic                   tri_last;
    logic [PIDX_W-1:0]      a_idx;
    logic [PIDX_W-1:0]      c_idx;
    logic [PIDX_W-1:0]      x1_idx;
    logic [PIDX_W-1:0]      x2_idx;

    logic [ID_WIDTH-1:0]    next_id_reg;
    logic [ID_WIDTH-1:0]    start_id_reg;
    logic                   ovf_reg;

    logic                   emit;
    logic                   out_load;
    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic                   out_last_reg;
    logic                   out_ovf_reg;
    logic [COORD_WIDTH-1:0] out_p_reg [NUM_COORD];
    logic [ID_WIDTH-1:0]    out_pid_reg;
    logic [ID_WIDTH-1:0]    out_va_reg;
    logic [ID_WIDTH-1:0]    out_vb_reg;
    logic [ID_WIDTH-1:0]    out_vc_reg;

    // Id of the point at a given place within the current item; the counter
    // saturates, so every later point shares the all-ones id.
    function automatic logic [ID_WIDTH-1:0] id_of(input logic [ID_WIDTH-1:0] base,
                                                  input logic [PIDX_W-1:0] p);
        logic [ID_WIDTH:0] sum;
        sum = {1'b0, base} + (ID_WIDTH+1)'(p);
        return sum[ID_WIDTH] ? ID_MAX : sum[ID_WIDTH-1:0];
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign n_clamped = (sub_reg == '0) ? SUB_W'(1) :
                       (sub_reg > SUB_W'(MAX_SUBDIVISIONS)) ? SUB_W'(MAX_SUBDIVISIONS) :
                       sub_reg;

    assign emit     = (state_reg == ST_POINTS) || (state_reg == ST_TRIS);
    assign out_load = emit && (!out_valid_reg || m_axis_tready);

    assign div_ctrl = '{start: div_start_reg, divisor: n_reg};

    utt_div #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (vin_reg[vsel_reg]),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r)
    );

    // Point grid walk.
    assign pt_row_end = (j_reg == SUB_W'(n_reg - i_reg));

    always_comb
    begin
        for (int c = 0; c < NUM_COORD; c++)
        begin
            pt_val[c] = cur_v_reg[c] + COORD_WIDTH'(round_frac(cur_rs_reg[c], n_reg));
        end
    end

    // Sub-triangle walk: row starts at s, the row above at t.
    assign tri_sum    = (SUB_W+1)'(j_reg) + (SUB_W+1)'(i_reg) + (SUB_W+1)'(1);
    assign tri_has_hi = (tri_sum < (SUB_W+1)'(n_reg));
    assign tri_last   = !tri_hi_reg && !tri_has_hi &&
                        ((SUB_W+1)'(i_reg) + (SUB_W+1)'(1) == (SUB_W+1)'(n_reg));
    assign a_idx      = tri_s_reg + PIDX_W'(j_reg);
    assign c_idx      = tri_t_reg + PIDX_W'(j_reg);
    assign x1_idx     = tri_hi_reg ? PIDX_W'(c_idx + PIDX_W'(1)) : PIDX_W'(a_idx + PIDX_W'(1));
    assign x2_idx     = tri_hi_reg ? PIDX_W'(a_idx + PIDX_W'(1)) : a_idx;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done && (vsel_reg == VSEL_W'(NUM_VERT - 1)))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_POINTS;
            end
            ST_POINTS:
            begin
                if (out_load && pt_row_end && (i_reg == n_reg))
                begin
                    state_next = ST_TRIS;
                end
            end
            ST_TRIS:
            begin
                if (out_load && tri_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sub_reg       <= SUB_W'(1);
            div_start_reg <= 1'b0;
            vsel_reg      <= '0;
            out_valid_reg <= 1'b0;
            next_id_reg   <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            tri_s_reg     <= '0;
            tri_t_reg     <= '0;
            tri_hi_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= in_accept ||
                             ((state_reg == ST_DIV) && div_done &&
                              (vsel_reg != VSEL_W'(NUM_VERT - 1)));
            if (cfg_we)
            begin
                sub_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        vsel_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (div_done && (vsel_reg != VSEL_W'(NUM_VERT - 1)))
                    begin
                        vsel_reg <= vsel_reg + VSEL_W'(1);
                    end
                end
                ST_SETUP:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
                ST_POINTS:
                begin
                    if (out_load)
                    begin
                        if (next_id_reg == ID_MAX)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            next_id_reg <= next_id_reg + ID_WIDTH'(1);
                        end
                        if (!pt_row_end)
                        begin
                            j_reg <= j_reg + SUB_W'(1);
                        end
                        else if (i_reg == n_reg)
                        begin
                            i_reg      <= '0;
                            j_reg      <= '0;
                            tri_s_reg  <= '0;
                            tri_t_reg  <= PIDX_W'(n_reg) + PIDX_W'(1);
                            tri_hi_reg <= 1'b0;
                        end
                        else
                        begin
                            i_reg <= i_reg + SUB_W'(1);
                            j_reg <= '0;
                        end
                    end
                end
                ST_TRIS:
                begin
                    if (out_load)
                    begin
                        if (!tri_hi_reg && tri_has_hi)
                        begin
                            tri_hi_reg <= 1'b1;
                        end
                        else if (tri_hi_reg)
                        begin
                            tri_hi_reg <= 1'b0;
                            j_reg      <= j_reg + SUB_W'(1);
                        end
                        else
                        begin
                            // End of a row: the row above becomes the base.
                            i_reg     <= i_reg + SUB_W'(1);
                            j_reg     <= '0;
                            tri_s_reg <= tri_t_reg;
                            tri_t_reg <= tri_t_reg + PIDX_W'(n_reg) - PIDX_W'(i_reg);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            n_reg        <= n_clamped;
            start_id_reg <= next_id_reg;
            for (int v = 0; v < NUM_VERT; v++)
            begin
                for (int c = 0; c < NUM_COORD; c++)
                begin
                    vin_reg[v][c] <=
                        s_axis_tdata[(v * NUM_COORD + c) * COORD_WIDTH +: COORD_WIDTH];
                end
            end
        end

        if ((state_reg == ST_DIV) && div_done)
        begin
            qv_reg[vsel_reg] <= div_q;
            rv_reg[vsel_reg] <= div_r;
        end

        // Start at the third vertex, where n*q2 equals the vertex minus r2
        // and the remainder sum is n*r2; then step by the quotient deltas.
        if (state_reg == ST_SETUP)
        begin
            for (int c = 0; c < NUM_COORD; c++)
            begin
                cur_v_reg[c]  <= vin_reg[2][c] - COORD_WIDTH'(rv_reg[2][c]);
                row_v_reg[c]  <= vin_reg[2][c] - COORD_WIDTH'(rv_reg[2][c]);
                cur_rs_reg[c] <= RS_W'(n_reg) * RS_W'(rv_reg[2][c]);
                row_rs_reg[c] <= RS_W'(n_reg) * RS_W'(rv_reg[2][c]);
                d1_reg[c]     <= qv_reg[1][c] - qv_reg[2][c];
                d0_reg[c]     <= qv_reg[0][c] - qv_reg[2][c];
                dr1_reg[c]    <= RS_W'(rv_reg[1][c]) - RS_W'(rv_reg[2][c]);
                dr0_reg[c]    <= RS_W'(rv_reg[0][c]) - RS_W'(rv_reg[2][c]);
            end
        end

        if ((state_reg == ST_POINTS) && out_load)
        begin
            for (int c = 0; c < NUM_COORD; c++)
            begin
                if (!pt_row_end)
                begin
                    cur_v_reg[c]  <= cur_v_reg[c] + d1_reg[c];
                    cur_rs_reg[c] <= cur_rs_reg[c] + dr1_reg[c];
                end
                else
                begin
                    row_v_reg[c]  <= row_v_reg[c] + d0_reg[c];
                    cur_v_reg[c]  <= row_v_reg[c] + d0_reg[c];
                    row_rs_reg[c] <= row_rs_reg[c] + dr0_reg[c];
                    cur_rs_reg[c] <= row_rs_reg[c] + dr0_reg[c];
                end
            end
        end

        if (out_load)
        begin
            if (state_reg == ST_POINTS)
            begin
                out_kind_reg <= 1'b0;
                out_last_reg <= 1'b0;
                out_p_reg    <= pt_val;
                out_pid_reg  <= next_id_reg;
                out_va_reg   <= '0;
                out_vb_reg   <= '0;
                out_vc_reg   <= '0;
                out_ovf_reg  <= ovf_reg || (next_id_reg == ID_MAX);
            end
            else
            begin
                out_kind_reg <= 1'b1;
                out_last_reg <= tri_last;
                for (int c = 0; c < NUM_COORD; c++)
                begin
                    out_p_reg[c] <= '0;
                end
                out_pid_reg  <= '0;
                out_va_reg   <= id_of(start_id_reg, c_idx);
                out_vb_reg   <= id_of(start_id_reg, x1_idx);
                out_vc_reg   <= id_of(start_id_reg, x2_idx);
                out_ovf_reg  <= ovf_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_ovf_reg, out_vc_reg, out_vb_reg, out_va_reg,
                                         out_pid_reg, out_p_reg[2], out_p_reg[1],
                                         out_p_reg[0]});

`ifndef SYNTHESIS
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("id overflow flag cleared without reset");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[3*COORD_WIDTH+ID_WIDTH-1:0] == '0))
        else $error("triangle item carries point data");

    a_last_tri: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("final item of a triangle is not a sub-triangle");
`endif

endmodule
`default_nettype wire
